FILE: hdl/pmso_pkg.sv
// Shared types, constants and the quarter-wave sine generator for the
// phase-modulated sine oscillator. No dependencies.
package pmso_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ENABLE       = 2'd0,
        CFG_PHASE_STEP   = 2'd1,
        CFG_PHASE_OFFSET = 2'd2
    } t_cfg_index;

    // Register values after reset.
    localparam logic                     RST_ENABLE       = 1'b1;
    localparam logic [CFG_DATA_BITS-1:0] RST_PHASE_STEP   = 32'd39370534;
    localparam logic [CFG_DATA_BITS-1:0] RST_PHASE_OFFSET = 32'h8000_0000;

    // Fixed-point constants for the table generator (Q30).
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

    // Control from the pipeline to the phase accumulator.
    typedef struct packed {
        logic advance;
        logic enable;
        logic note_on;
    } t_acc_ctrl;

    // Quarter-wave sine magnitude at position r of 2^qbits, scaled to
    // 2^frac - 1. Evaluated at elaboration only, to build the table.
    function automatic logic [63:0] quarter_sine(input int unsigned r,
                                                 input int unsigned qbits,
                                                 input int unsigned frac);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (64'(r) * HALF_PI_Q30) >> qbits;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        return (s * ((64'd1 << frac) - 64'd1) + (64'd1 << 29)) >> 30;
    endfunction

endpackage

FILE: hdl/pmso_sine_rom.sv
// Full-wave sine lookup built from a quarter-wave constant table.
// Depends on pmso_pkg for the table generator function.
module pmso_sine_rom #(
    parameter int SAMPLE_BITS    = 16,
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic [SINE_ADDR_BITS-1:0] i_addr,
    output logic [SAMPLE_BITS-2:0]    o_mag,
    output logic                      o_neg
);
    import pmso_pkg::*;

    localparam int FRAC_BITS = SAMPLE_BITS - 1;
    localparam int QB        = SINE_ADDR_BITS - 2;
    localparam int Q         = 1 << QB;

    logic [FRAC_BITS-1:0] w_tab [0:Q];
    logic [1:0]           w_quad;
    logic [QB-1:0]        w_pos;
    logic [QB:0]          w_idx;

    // Quarter-wave table, one entry beyond the quarter for the mirrored quadrants.
    for (genvar gi = 0; gi <= Q; gi++) begin : g_tab
        assign w_tab[gi] = FRAC_BITS'(quarter_sine(gi, QB, FRAC_BITS));
    end

    // Odd quadrants run the quarter backwards; the second half is negative.
    assign w_quad = i_addr[SINE_ADDR_BITS-1 -: 2];
    assign w_pos  = i_addr[QB-1:0];
    assign w_idx  = w_quad[0] ? ((QB+1)'(Q) - {1'b0, w_pos}) : {1'b0, w_pos};
    assign o_mag  = w_tab[w_idx];
    assign o_neg  = w_quad[1];

endmodule

FILE: hdl/pmso_phase_acc.sv
// Phase accumulator with note-on clear, and the total phase for the lookup.
// Depends on pmso_pkg for the control struct.
module pmso_phase_acc #(
    parameter int PHASE_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pmso_pkg::t_acc_ctrl       i_ctrl,
    input  logic [PHASE_BITS-1:0]     i_inc,
    input  logic [PHASE_BITS-1:0]     i_pm_off,
    output logic [PHASE_BITS-1:0]     o_total
);
    import pmso_pkg::*;

    logic [PHASE_BITS-1:0] r_phase_acc;
    logic [PHASE_BITS-1:0] n_phase_acc;
    logic [PHASE_BITS-1:0] w_base;

    // A note-on starts this word from phase zero.
    assign w_base      = i_ctrl.note_on ? '0 : r_phase_acc;
    assign o_total     = w_base + i_pm_off;
    assign n_phase_acc = w_base + i_inc;

    // The accumulator moves once per word, and only while enabled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc <= '0;
        end else if (i_ctrl.advance && i_ctrl.enable) begin
            r_phase_acc <= n_phase_acc;
        end
    end

    // A disabled oscillator never moves its phase.
    a_hold_when_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.advance && !i_ctrl.enable) |=> $stable(r_phase_acc))
        else $error("phase moved while disabled");

endmodule

FILE: hdl/pmso_gain.sv
// Volume scaling of the sine magnitude with rounding half away from zero.
// Depends on pmso_pkg only by convention; pure arithmetic.
module pmso_gain #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic [SAMPLE_BITS-2:0]        i_mag,
    input  logic                          i_neg,
    input  logic [SAMPLE_BITS-1:0]        i_gain,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);
    import pmso_pkg::*;

    localparam int FRAC_BITS = SAMPLE_BITS - 1;
    localparam int PW        = FRAC_BITS + SAMPLE_BITS + 1;

    logic [PW-1:0]          w_prod;
    logic [FRAC_BITS-1:0]   w_res;
    logic [SAMPLE_BITS-1:0] w_pos;

    // Gain is (volume + 1) / 2, so the product drops one extra bit.
    assign w_prod   = PW'(i_mag) * PW'(i_gain) + (PW'(1) << FRAC_BITS);
    assign w_res    = w_prod[SAMPLE_BITS +: FRAC_BITS];
    assign w_pos    = {1'b0, w_res};
    assign o_sample = i_neg ? -w_pos : w_pos;

endmodule

FILE: hdl/pm_sine_oscillator_core.sv
// Phase-modulated sine oscillator core (direct digital synthesis).
// Depends on pmso_pkg, pmso_phase_acc, pmso_sine_rom and pmso_gain.
//
// Usage:
// - Input channel (i_in_valid / o_in_stall) carries one word per sample:
//   phase, volume and pitch modulation and a note-on flag.
// - Output channel (o_out_valid / i_out_stall) returns one sample word for
//   every input word, in order.
// - Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data):
//   enable, phase step and phase offset. Write it only while no word is in
//   flight.
// - Throughput is one word per clock while the receiver does not stall. The
//   accumulator feedback is a single add in the phase and table stage, which
//   sets that rate. The pipeline has an input register, a step-multiply stage,
//   a phase and table stage, and the output register.
// - When the receiver stalls, full stages hold and bubbles close up; the
//   input stalls only once every stage holds a word.
// - Reset empties the pipeline, clears the phase and loads enable = 1,
//   the default step and a half-turn offset.
module pm_sine_oscillator_core #(
    parameter int PHASE_BITS     = 32,
    parameter int SAMPLE_BITS    = 16,
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write port
    input  logic                                   i_cfg_we,
    input  logic [pmso_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [pmso_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    // Input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]          i_phase_mod,
    input  logic signed [SAMPLE_BITS-1:0]          i_volume_mod,
    input  logic signed [SAMPLE_BITS-1:0]          i_pitch_mod,
    input  logic                                   i_note_on,
    // Output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]          o_sample
);
    import pmso_pkg::*;

    localparam int FRAC_BITS = SAMPLE_BITS - 1;
    localparam int PROD_BITS = PHASE_BITS + SAMPLE_BITS + 1;

    // Configuration registers
    logic                     r_enable;
    logic [CFG_DATA_BITS-1:0] r_phase_step;
    logic [CFG_DATA_BITS-1:0] r_phase_offset;

    // Stage valids and the ready chain
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;
    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;
    logic w_rdy4;

    // Stage 1: input register
    logic signed [SAMPLE_BITS-1:0] r1_phase_mod;
    logic signed [SAMPLE_BITS-1:0] r1_volume_mod;
    logic signed [SAMPLE_BITS-1:0] r1_pitch_mod;
    logic                          r1_note_on;

    // Stage 2: increment, phase offset sum, gain
    logic [PHASE_BITS-1:0]  r2_inc;
    logic [PHASE_BITS-1:0]  r2_pm_off;
    logic [SAMPLE_BITS-1:0] r2_gain;
    logic                   r2_note_on;

    // Stage 3: table magnitude and sign
    logic [FRAC_BITS-1:0]   r3_mag;
    logic                   r3_neg;
    logic [SAMPLE_BITS-1:0] r3_gain;

    // Output register
    logic signed [SAMPLE_BITS-1:0] r_sample;

    // Combinational signals
    logic [PHASE_BITS+CFG_DATA_BITS-1:0] w_step_ext;
    logic [PHASE_BITS+CFG_DATA_BITS-1:0] w_off_ext;
    logic [PHASE_BITS+SAMPLE_BITS-1:0]   w_pm_ext;
    logic [PHASE_BITS-1:0]               w_step_ph;
    logic [PHASE_BITS-1:0]               w_off_ph;
    logic [PHASE_BITS-1:0]               w_pm_ph;
    logic [SAMPLE_BITS:0]                w_mult;
    logic [PROD_BITS-1:0]                w_step_prod;
    logic [PHASE_BITS-1:0]               w_total;
    logic [FRAC_BITS-1:0]                w_mag;
    logic                                w_neg;
    logic signed [SAMPLE_BITS-1:0]       w_sample;
    t_acc_ctrl                           w_acc_ctrl;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= RST_ENABLE;
            r_phase_step   <= RST_PHASE_STEP;
            r_phase_offset <= RST_PHASE_OFFSET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENABLE:       r_enable       <= i_cfg_data[0];
                CFG_PHASE_STEP:   r_phase_step   <= i_cfg_data;
                CFG_PHASE_OFFSET: r_phase_offset <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Each stage takes a word when empty or when its word moves on.
    assign w_rdy4     = !r_v4 || !i_out_stall;
    assign w_rdy3     = !r_v3 || w_rdy4;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_stall = !w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Registers scaled to the accumulator width, truncating when narrower.
    assign w_step_ext = {r_phase_step, {PHASE_BITS{1'b0}}};
    assign w_off_ext  = {r_phase_offset, {PHASE_BITS{1'b0}}};
    assign w_step_ph  = w_step_ext[CFG_DATA_BITS +: PHASE_BITS];
    assign w_off_ph   = w_off_ext[CFG_DATA_BITS +: PHASE_BITS];

    // Phase modulation in turns, floored to the accumulator resolution.
    assign w_pm_ext = {r1_phase_mod, {PHASE_BITS{1'b0}}};
    assign w_pm_ph  = w_pm_ext[FRAC_BITS +: PHASE_BITS];

    // Increment is step * (pitch + 2), pitch in Q1.F.
    assign w_mult      = {r1_pitch_mod[SAMPLE_BITS-1], r1_pitch_mod}
                       + {1'b1, {SAMPLE_BITS{1'b0}}};
    assign w_step_prod = PROD_BITS'(w_step_ph) * PROD_BITS'(w_mult);

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_rdy1) begin
            r1_phase_mod  <= i_phase_mod;
            r1_volume_mod <= i_volume_mod;
            r1_pitch_mod  <= i_pitch_mod;
            r1_note_on    <= i_note_on;
        end
        if (r_v1 && w_rdy2) begin
            r2_inc     <= w_step_prod[FRAC_BITS +: PHASE_BITS];
            r2_pm_off  <= w_pm_ph + w_off_ph;
            r2_gain    <= {~r1_volume_mod[SAMPLE_BITS-1], r1_volume_mod[SAMPLE_BITS-2:0]};
            r2_note_on <= r1_note_on;
        end
        if (r_v2 && w_rdy3) begin
            r3_mag  <= r_enable ? w_mag : '0;
            r3_neg  <= w_neg;
            r3_gain <= r2_gain;
        end
        if (r_v3 && w_rdy4) begin
            r_sample <= w_sample;
        end
    end

    // Accumulator steps as a word leaves stage two.
    assign w_acc_ctrl.advance = r_v2 && w_rdy3;
    assign w_acc_ctrl.enable  = r_enable;
    assign w_acc_ctrl.note_on = r2_note_on;

    pmso_phase_acc #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_acc_ctrl),
        .i_inc    (r2_inc),
        .i_pm_off (r2_pm_off),
        .o_total  (w_total)
    );

    pmso_sine_rom #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_sine_rom (
        .i_addr (w_total[PHASE_BITS-1 -: SINE_ADDR_BITS]),
        .o_mag  (w_mag),
        .o_neg  (w_neg)
    );

    pmso_gain #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_gain (
        .i_mag    (r3_mag),
        .i_neg    (r3_neg),
        .i_gain   (r3_gain),
        .o_sample (w_sample)
    );

    assign o_out_valid = r_v4;
    assign o_sample    = r_sample;

    // The input stalls only when every stage is full and the output waits.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && i_out_stall))
        else $error("input stalled with room in the pipeline");

    // Reset leaves no word on the output.
    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output word present straight after reset");

    // Samples stay inside the symmetric range.
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample != {1'b1, {FRAC_BITS{1'b0}}}))
        else $error("sample reached the most negative code");

endmodule

FILE: test/pm_sine_oscillator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for pm_sine_oscillator_core: a queue-fed driver, a
// monitor and a behavioural model of the oscillator that predicts each sample.
// Depends on pmso_pkg and the core RTL.
module pm_sine_oscillator_core_tb;
    import pmso_pkg::*;

    localparam int SMP_W       = 16;
    localparam int FRAC        = SMP_W - 1;
    localparam int LUT_BITS    = 10;
    localparam int QTR         = 1 << (LUT_BITS - 2);
    localparam int PIPE_DEPTH  = 3;
    localparam int HOLD_CYCLES = 240;
    localparam logic [63:0] HALF_PI_Q30_TB = 64'd1686629713;
    localparam logic [63:0] ONE_Q30        = 64'd1 << 30;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam logic signed [SMP_W-1:0] S_MIN = 16'sh8000;
    localparam logic signed [SMP_W-1:0] S_MAX = 16'sh7FFF;

    typedef struct packed {
        logic signed [SMP_W-1:0] phase_mod;
        logic signed [SMP_W-1:0] volume_mod;
        logic signed [SMP_W-1:0] pitch_mod;
        logic                    note_on;
    } t_mod_word;

    // Block ports.
    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]    cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic signed [SMP_W-1:0]     phase_mod = '0;
    logic signed [SMP_W-1:0]     volume_mod = '0;
    logic signed [SMP_W-1:0]     pitch_mod = '0;
    logic                        note_on = 1'b0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [SMP_W-1:0]     sample;

    // Stimulus and expected samples.
    t_mod_word                   mod_words[$];
    t_mod_word                   live_word;
    logic signed [SMP_W-1:0]     sine_samples[$];
    int                          words_sent = 0;
    int                          samples_seen = 0;
    int                          error_count = 0;
    int                          send_idle_pct = 0;
    int                          stall_pct = 0;
    int                          hold_serial = 0;
    int                          hold_taken = 0;
    int                          hold_left = 0;

    // Model state and its copy of the registers.
    int                          sine_lut[1 << LUT_BITS];
    logic                        osc_enable;
    logic [31:0]                 osc_step;
    logic [31:0]                 osc_offset;
    logic [31:0]                 osc_phase;

    pm_sine_oscillator_core i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_phase_mod  (phase_mod),
        .i_volume_mod (volume_mod),
        .i_pitch_mod  (pitch_mod),
        .i_note_on    (note_on),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_sample     (sample)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Quarter-wave magnitude: Taylor series in Horner form, truncated in Q30,
    // then scaled to full scale with rounding half up.
    function automatic int quarter_wave(input int unsigned r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        int unsigned divs[5] = '{110, 72, 42, 20, 6};
        x  = (64'(r) * HALF_PI_Q30_TB) >> (LUT_BITS - 2);
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        foreach (divs[i]) begin
            t = ONE_Q30 - ((x2 * t) >> 30) / 64'(divs[i]);
        end
        s = (x * t) >> 30;
        if (s > ONE_Q30) begin
            s = ONE_Q30;
        end
        return int'((s * ((64'd1 << FRAC) - 64'd1) + (64'd1 << 29)) >> 30);
    endfunction

    // Produces the sample for one word and, while enabled, advances the phase accumulator.
    function automatic logic signed [SMP_W-1:0] oscillate(input t_mod_word w);
        logic [31:0] total;
        logic [63:0] mag;
        logic [63:0] mult;
        logic [63:0] incr;
        int          s;
        if (!osc_enable) begin
            return '0;
        end
        if (w.note_on) begin
            osc_phase = '0;
        end
        // One unit of phase modulation is a full turn, so its lowest bit lands at bit 17.
        total = osc_phase + {w.phase_mod[FRAC-1:0], 17'b0} + osc_offset;
        s     = sine_lut[total[31:32-LUT_BITS]];
        mag   = 64'(s < 0 ? -s : s) * 64'(int'(w.volume_mod) + (1 << FRAC));
        mag   = (mag + (64'd1 << FRAC)) >> (FRAC + 1);
        mult  = 64'(int'(w.pitch_mod) + (1 << (FRAC + 1)));
        incr  = (64'(osc_step) * mult) >> FRAC;
        osc_phase = osc_phase + incr[31:0];
        return (s < 0) ? -SMP_W'(mag) : SMP_W'(mag);
    endfunction

    task automatic report_mismatch(input string what, input logic signed [SMP_W-1:0] got,
                                   input logic signed [SMP_W-1:0] want);
        $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Driver: predicts each accepted word, then offers the next one or idles.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                sine_samples.push_back(oscillate(live_word));
            end
            if (!in_valid || !in_stall) begin
                if (mod_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    live_word   = mod_words.pop_front();
                    in_valid   <= 1'b1;
                    phase_mod  <= live_word.phase_mod;
                    volume_mod <= live_word.volume_mod;
                    pitch_mod  <= live_word.pitch_mod;
                    note_on    <= live_word.note_on;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: random, or a long hold-off when one is requested.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (hold_taken != hold_serial) begin
            hold_taken <= hold_serial;
            hold_left  <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: every accepted sample is checked against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            samples_seen++;
            if (sine_samples.size() == 0) begin
                report_mismatch("sample with none expected", sample, '0);
            end else if (sample !== sine_samples[0]) begin
                report_mismatch("sample", sample, sine_samples.pop_front());
            end else begin
                void'(sine_samples.pop_front());
            end
        end
    end

    // Register writes strobe the write enable and drop it again before the next write.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLE:       osc_enable = data[0];
            CFG_PHASE_STEP:   osc_step   = data;
            CFG_PHASE_OFFSET: osc_offset = data;
            default:          ;
        endcase
    endtask

    task automatic push_word(input logic signed [SMP_W-1:0] pm, input logic signed [SMP_W-1:0] vm,
                             input logic signed [SMP_W-1:0] pt, input logic on);
        t_mod_word w;
        w.phase_mod  = pm;
        w.volume_mod = vm;
        w.pitch_mod  = pt;
        w.note_on    = on;
        mod_words.push_back(w);
        words_sent++;
    endtask

    // Waits until every sample sent so far has come back and the pipe is empty.
    task automatic settle();
        while (samples_seen != words_sent) begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // Mostly full-range values, with the extremes and values near zero mixed in.
    function automatic logic signed [SMP_W-1:0] pick_mod();
        case ($urandom_range(9))
            0: return S_MIN;
            1: return S_MAX;
            2: return SMP_W'($urandom_range(3)) - 16'sd2;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int n_words, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (n_words) begin
            push_word(pick_mod(), pick_mod(), pick_mod(), $urandom_range(15) == 0);
        end
        settle();
    endtask

    initial begin
        int unsigned r;
        // Sine table from quarter-wave symmetry.
        for (int k = 0; k < (1 << LUT_BITS); k++) begin
            r = k % QTR;
            case (k / QTR)
                0:       sine_lut[k] =  quarter_wave(r);
                1:       sine_lut[k] =  quarter_wave(QTR - r);
                2:       sine_lut[k] = -quarter_wave(r);
                default: sine_lut[k] = -quarter_wave(QTR - r);
            endcase
        end
        osc_enable = RST_ENABLE;
        osc_step   = RST_PHASE_STEP;
        osc_offset = RST_PHASE_OFFSET;
        osc_phase  = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset settings: field extremes and note-on.
        push_word('0, '0, '0, 1'b1);
        push_word('0, S_MAX, '0, 1'b0);
        push_word('0, S_MIN, '0, 1'b0);
        push_word(S_MAX, '0, '0, 1'b0);
        push_word(S_MIN, '0, '0, 1'b0);
        push_word('0, '0, S_MAX, 1'b0);
        push_word('0, '0, S_MIN, 1'b0);
        push_word(S_MIN, S_MIN, S_MIN, 1'b1);
        push_word(S_MAX, S_MAX, S_MAX, 1'b0);
        push_word(-16'sd1, -16'sd1, -16'sd1, 1'b0);
        push_word(16'sh4000, S_MAX, '0, 1'b0);
        push_word(16'shC000, S_MAX, '0, 1'b1);
        repeat (4) push_word('0, S_MAX, S_MAX, 1'b0);
        settle();

        // Disabled: zero output, phase holds and note-on has no effect.
        // Only bit 0 of the enable register counts.
        write_reg(CFG_ENABLE, 32'hFFFF_FFFE);
        push_word('0, S_MAX, '0, 1'b1);
        push_word(S_MAX, S_MAX, S_MAX, 1'b0);
        push_word(S_MIN, '0, S_MIN, 1'b1);
        settle();
        write_reg(CFG_ENABLE, 32'h0000_0001);

        // Half-turn step and the largest offset, so that phase sums wrap.
        write_reg(CFG_PHASE_STEP, 32'h8000_0000);
        write_reg(CFG_PHASE_OFFSET, 32'hFFFF_FFFF);
        repeat (3) push_word('0, S_MAX, S_MAX, 1'b0);
        push_word(S_MAX, S_MAX, '0, 1'b0);
        settle();

        // Zero step and offset; the receiver holds off long enough to fill
        // the pipe while the sender keeps offering words.
        write_reg(CFG_PHASE_STEP, 32'h0);
        write_reg(CFG_PHASE_OFFSET, 32'h0);
        write_reg(CFG_SPARE, $urandom);
        hold_serial++;
        random_phase(160, 0, 0);

        write_reg(CFG_PHASE_STEP, $urandom);
        write_reg(CFG_PHASE_OFFSET, $urandom);
        random_phase(160, 51, 0);

        write_reg(CFG_PHASE_STEP, $urandom_range(32'h8000_0000, 0));
        write_reg(CFG_PHASE_OFFSET, $urandom);
        random_phase(160, 0, 51);

        write_reg(CFG_PHASE_STEP, $urandom_range(32'h0100_0000, 0));
        write_reg(CFG_PHASE_OFFSET, $urandom);
        random_phase(160, 7, 7);

        write_reg(CFG_ENABLE, $urandom & 32'hFFFF_FFFE);
        random_phase(80, 7, 7);

        write_reg(CFG_ENABLE, $urandom | 32'h1);
        write_reg(CFG_PHASE_STEP, RST_PHASE_STEP);
        write_reg(CFG_PHASE_OFFSET, RST_PHASE_OFFSET);
        hold_serial++;
        random_phase(230, 0, 0);

        if (error_count == 0 && sine_samples.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
